// ===== design/binary_majority_filter_unit_defines.svh =====
`ifndef BINARY_MAJORITY_FILTER_UNIT_DEFINES_SVH
`define BINARY_MAJORITY_FILTER_UNIT_DEFINES_SVH

// same-cycle implication
`define BMF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmf assertion failed");

// next-cycle implication
`define BMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmf assertion failed");

`endif

// ===== design/bmf_pkg.sv =====
`default_nettype none

package bmf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WID_W       = 11;
   localparam int HGT_W       = 13;
   localparam int ROW_W       = HGT_W;
   localparam int ADDR_W      = COL_W + 1;
   localparam int LINE_DEPTH  = 2 * MAX_WIDTH;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              drain;
      logic              pix;
      logic              first_col;
      logic              last_col;
      logic              one_col;
      logic              up_ok;
      logic              emit;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } front_cmd_type;

   typedef struct packed {
      logic up;
      logic up_ok;
      logic dn;
      logic dn_ok;
      logic lf;
      logic lf_ok;
      logic rt;
      logic rt_ok;
      logic cen;
      logic last;
   } taps_type;

endpackage

`default_nettype wire

// ===== design/bmf_front.sv =====
`default_nettype none

module bmf_front
   import bmf_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_opcode,
   input  wire                   req_in_pixel,
   input  wire                   credit_ok,
   input  wire                   csr_write_enable,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data,
   output front_cmd_type         cmd
);

   logic [WID_W-1:0] width_ff, width_in;
   logic [HGT_W-1:0] height_ff, height_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] col_next;
   logic             is_drain;
   logic             frame_in;
   logic             last_col;

   function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] v);
      logic [WID_W-1:0] r;
      r = v;
      if (v == '0) r = WID_W'(1);
      else if (v > WID_W'(MAX_WIDTH)) r = WID_W'(MAX_WIDTH);
      return r;
   endfunction

   function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
      logic [HGT_W-1:0] r;
      r = v;
      if (v == '0) r = HGT_W'(1);
      else if (v > HGT_W'(MAX_HEIGHT)) r = HGT_W'(MAX_HEIGHT);
      return r;
   endfunction

   assign req_ready = credit_ok;

   always_comb begin
      is_drain = (req_opcode == OP_DRAIN);
      frame_in = (row_ff == height_ff);
      last_col = (WID_W'(col_ff) == width_ff - WID_W'(1));
      col_next = col_ff + COL_W'(1);

      cmd.valid     = req_valid && credit_ok && (is_drain == frame_in);
      cmd.drain     = is_drain;
      cmd.pix       = req_in_pixel;
      cmd.first_col = (col_ff == '0);
      cmd.last_col  = last_col;
      cmd.one_col   = (width_ff == WID_W'(1));
      cmd.up_ok     = (row_ff >= ROW_W'(2));
      cmd.emit      = is_drain || (row_ff != '0);
      cmd.addr_a    = {row_ff[0], col_ff};
      cmd.addr_b    = last_col ? {row_ff[0], COL_W'(0)} : {~row_ff[0], col_next};
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (csr_write_enable) begin
         row_in = '0;
         col_in = '0;
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = clamp_width(csr_data[WID_W-1:0]);
            REG_IMAGE_HEIGHT: height_in = clamp_height(csr_data[HGT_W-1:0]);
         endcase
      end else if (cmd.valid) begin
         if (last_col) begin
            col_in = '0;
            row_in = is_drain ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(MAX_WIDTH);
         height_ff <= HGT_W'(1);
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bmf_window.sv =====
`default_nettype none

module bmf_window
   import bmf_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  front_cmd_type cmd,
   output taps_type      taps,
   output logic          taps_valid
);

   logic          line_mem [LINE_DEPTH];
   logic          up_rd_ff;
   logic          rt_rd_ff;
   front_cmd_type s1_ff;
   logic          cen_ff, cen_in;
   logic          lft_ff, lft_in;

   // read-before-write on the shared address: up tap sees the older row
   always_ff @(posedge clock) begin
      if (cmd.valid && !cmd.drain) begin
         line_mem[cmd.addr_a] <= cmd.pix;
      end
      up_rd_ff <= line_mem[cmd.addr_a];
      rt_rd_ff <= line_mem[cmd.addr_b];
   end

   always_comb begin
      cen_in = cen_ff;
      lft_in = lft_ff;
      if (s1_ff.valid) begin
         if (s1_ff.last_col) begin
            // prefetch column 0 of the row just finished
            cen_in = s1_ff.one_col ? s1_ff.pix : rt_rd_ff;
         end else begin
            cen_in = rt_rd_ff;
            lft_in = cen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= cmd;
      end
      cen_ff <= cen_in;
      lft_ff <= lft_in;
   end

   always_comb begin
      taps.up    = up_rd_ff;
      taps.up_ok = s1_ff.up_ok;
      taps.dn    = s1_ff.pix;
      taps.dn_ok = !s1_ff.drain;
      taps.lf    = lft_ff;
      taps.lf_ok = !s1_ff.first_col;
      taps.rt    = rt_rd_ff;
      taps.rt_ok = !s1_ff.last_col;
      taps.cen   = cen_ff;
      taps.last  = s1_ff.drain && s1_ff.last_col;
      taps_valid = s1_ff.valid && s1_ff.emit;
   end

endmodule

`default_nettype wire

// ===== design/bmf_queue.sv =====
`default_nettype none

module bmf_queue
   import bmf_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  taps_type          push_data,
   input  wire               pop,
   output taps_type          head,
   output logic              not_empty,
   output logic [QCNT_W-1:0] count
);

   taps_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

// ===== design/bmf_back.sv =====
`default_nettype none

module bmf_back
   import bmf_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      q_valid,
   input  taps_type head,
   output logic     q_pop,
   output logic     rsp_valid,
   input  wire      rsp_ready,
   output logic     rsp_out_pixel,
   output logic     rsp_frame_last
);

   logic rsp_valid_ff, rsp_valid_in;
   logic pixel_ff, pixel_in;
   logic last_ff, last_in;

   function automatic logic majority(input taps_type t);
      logic [2:0] black;
      logic [2:0] seen;
      logic [2:0] white;
      logic       r;
      black = 3'(t.up_ok & t.up) + 3'(t.dn_ok & t.dn)
            + 3'(t.lf_ok & t.lf) + 3'(t.rt_ok & t.rt);
      seen  = 3'(t.up_ok) + 3'(t.dn_ok) + 3'(t.lf_ok) + 3'(t.rt_ok);
      white = seen - black;
      if (black > white) r = 1'b1;
      else if (white > black) r = 1'b0;
      else r = t.cen;
      return r;
   endfunction

   always_comb begin
      q_pop        = q_valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff;
      pixel_in     = pixel_ff;
      last_in      = last_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         pixel_in     = majority(head);
         last_in      = head.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      pixel_ff <= pixel_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_pixel  = pixel_ff;
   assign rsp_frame_last = last_ff;

endmodule

`default_nettype wire

// ===== design/binary_majority_filter_unit.sv =====
// channel   dir  handshake            payload
// req       in   req_valid/req_ready  req_opcode, req_in_pixel
// rsp       out  rsp_valid/rsp_ready  rsp_out_pixel, rsp_frame_last
// csr       in   csr_write_enable     csr_index, csr_data
//
// One transaction per clock sustained while req_ready is high; a result passes the
// window stage, queue and output register, one image row behind the pixel stream.
// The line store is read at two addresses and written at one per cycle, all at accept.
// Reset loads width 1024, height 1 and restarts the frame; the line store is not cleared.
// A four-entry queue feeds the output stage; req_ready drops only when the queue
// and the item in flight would fill it while rsp is stalled.
`default_nettype none

module binary_majority_filter_unit
   import bmf_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_opcode,
   input  wire                   req_in_pixel,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic                  rsp_out_pixel,
   output logic                  rsp_frame_last,
   input  wire                   csr_write_enable,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data
);

   front_cmd_type     cmd;
   taps_type          taps;
   taps_type          head;
   logic              taps_valid;
   logic              q_not_empty;
   logic              q_pop;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W:0]   occupancy;
   logic              credit_ok;

   assign occupancy = {1'b0, q_count} + (QCNT_W+1)'(taps_valid);
   assign credit_ok = (occupancy < (QCNT_W+1)'(QUEUE_DEPTH));

   bmf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_in_pixel     (req_in_pixel),
      .credit_ok        (credit_ok),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd)
   );

   bmf_window u_window (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .taps       (taps),
      .taps_valid (taps_valid)
   );

   bmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (taps_valid),
      .push_data (taps),
      .pop       (q_pop),
      .head      (head),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   bmf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .head           (head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ===== design/bmf_checker.sv =====
`default_nettype none
`include "binary_majority_filter_unit_defines.svh"

module bmf_checker (
   input wire clock,
   input wire reset,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_out_pixel,
   input wire rsp_frame_last
);

   logic       rsp_stall;
   logic [1:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_pixel, rsp_frame_last};

   // output register is empty right after reset
   `BMF_ASSERT_NEXT(a_rsp_idle_after_reset, clock, 1'b0, reset, !rsp_valid)

   // input backpressure only comes from a stalled result
   `BMF_ASSERT_IMPLY(a_stall_needs_pending_rsp, clock, reset, !req_ready, rsp_valid)

   `BMF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind binary_majority_filter_unit bmf_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_pixel  (rsp_out_pixel),
   .rsp_frame_last (rsp_frame_last)
);

`default_nettype wire
